// ===== sv/tlbpt_pkg.sv =====
// shared types and constants for the page table translator
`default_nettype none
package tlbpt_pkg;
    localparam int unsigned MODE_FIFO = 0;
    localparam int unsigned MODE_LRU  = 1;
    localparam int unsigned STAMP_W   = 32;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOK   = 7'b0000010,
        ST_LRU    = 7'b0000100,
        ST_OWNER  = 7'b0001000,
        ST_VICTIM = 7'b0010000,
        ST_WRITE  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } tlbpt_state_t;
endpackage
`default_nettype wire

// ===== sv/tlb_page_table_translator.sv =====
// top level: tlb, page map memory, frame memories and the access sequencer
// sequence: a tlb or page map hit, or a fault while free frames remain, goes look, write,
//   out; with all frames in use a fault adds owner and victim (and an lru stamp sweep)
// one beat at a time: no input beat is accepted until the result beat has been taken
// reset: after aresetn low, a clearing pass empties the page map
//   memory; no input beat is accepted until it ends, configuration writes are taken
`default_nettype none
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 1024,
    parameter int FRAME_COUNT  = 256,
    parameter int OFFSET_WIDTH = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [OFFSET_WIDTH+$clog2(PAGE_COUNT)-1:0] s_virtual_address,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [OFFSET_WIDTH+$clog2(FRAME_COUNT)-1:0]     m_phys_addr,
    output logic                        m_tlb_hit,
    output logic                        m_page_fault,
    output logic                        m_evicted_valid,
    output logic [$clog2(PAGE_COUNT)-1:0]                   m_evicted_page
);
    localparam int PW = $clog2(PAGE_COUNT);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int TW = $clog2(TLB_ENTRIES);

    tlbpt_state_t state_reg, state_next;
    logic [PW:0]   clr_reg;
    logic          clearing;
    logic [PW-1:0] page_reg;
    logic [OFFSET_WIDTH-1:0] off_reg;
    logic [FW-1:0] frame_reg, ffill_reg, best_reg;
    logic [STAMP_W-1:0] best_st_reg, count_reg;
    logic [FW:0]   scan_reg;
    logic          full_reg, hit_reg, fault_reg, ev_reg;
    logic [PW-1:0] evp_reg;

    logic mode_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= 1'b0;
        else if (cfg_valid) mode_reg <= cfg_data;
    end

    // page map memory: valid + frame
    logic [FW:0]  pmap_mem [PAGE_COUNT];
    logic [PW-1:0] pm_raddr, pm_waddr;
    logic [FW:0]  pm_rdata_reg, pm_wdata;
    logic         pm_we;
    always_ff @(posedge aclk) begin
        if (pm_we) pmap_mem[pm_waddr] <= pm_wdata;
        pm_rdata_reg <= pmap_mem[pm_raddr];
    end

    // frame owner and stamp memories
    logic [PW-1:0]      owner_mem [FRAME_COUNT];
    logic [STAMP_W-1:0] stamp_mem [FRAME_COUNT];
    logic [FW-1:0]      fo_raddr, st_raddr, fr_waddr;
    logic [PW-1:0]      fo_rdata_reg, fo_wdata;
    logic [STAMP_W-1:0] st_rdata_reg;
    logic               fo_we, st_we;
    always_ff @(posedge aclk) begin
        if (fo_we) owner_mem[fr_waddr] <= fo_wdata;
        if (st_we) stamp_mem[fr_waddr] <= count_reg;
        fo_rdata_reg <= owner_mem[fo_raddr];
        st_rdata_reg <= stamp_mem[st_raddr];
    end

    // tlb
    logic [PW-1:0] tag_reg [TLB_ENTRIES];
    logic [FW-1:0] tgt_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tv_reg, tv_next;
    logic [TW-1:0] tfill_reg;

    assign clearing = !clr_reg[PW];
    assign s_ready  = (state_reg == ST_IDLE) && !clearing;

    // tlb lookup, lowest index wins
    logic          thit;
    logic [FW-1:0] tframe;
    always_comb begin
        thit = 1'b0;
        tframe = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (tv_reg[i] && tag_reg[i] == page_reg) begin
                thit = 1'b1;
                tframe = tgt_reg[i];
            end
        end
    end

    logic [FW-1:0] scan_idx;
    logic [FW-1:0] lru_pick;
    assign scan_idx = scan_reg[FW-1:0];
    assign lru_pick = (scan_reg > (FW+1)'(1) && st_rdata_reg < best_st_reg) ?
                      FW'(scan_reg - 1'b1) : best_reg;

    always_comb begin
        pm_raddr = page_reg;
        fo_raddr = frame_reg;
        st_raddr = scan_idx;
        case (state_reg)
            ST_IDLE:  pm_raddr = s_virtual_address[OFFSET_WIDTH +: PW];
            ST_LOOK:  fo_raddr = ffill_reg;
            ST_LRU:   fo_raddr = lru_pick;
            ST_OWNER: pm_raddr = fo_rdata_reg;
            default: ;
        endcase
    end

    // page map and frame writes
    always_comb begin
        pm_we = 1'b0;
        pm_waddr = page_reg;
        pm_wdata = {1'b1, frame_reg};
        fo_we = 1'b0;
        fo_wdata = page_reg;
        st_we = 1'b0;
        fr_waddr = frame_reg;
        if (clearing) begin
            pm_we = 1'b1;
            pm_waddr = clr_reg[PW-1:0];
            pm_wdata = '0;
        end else if (state_reg == ST_VICTIM) begin
            if (pm_rdata_reg[FW] && pm_rdata_reg[FW-1:0] == frame_reg) begin
                pm_we = 1'b1;
                pm_waddr = fo_rdata_reg;
                pm_wdata = '0;
            end
        end else if (state_reg == ST_WRITE) begin
            pm_we = fault_reg;
            fo_we = fault_reg;
            st_we = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid && !clearing) state_next = ST_LOOK;
            ST_LOOK: begin
                if (thit || pm_rdata_reg[FW]) state_next = ST_WRITE;
                else if (full_reg && mode_reg == 1'(MODE_LRU)) state_next = ST_LRU;
                else if (full_reg) state_next = ST_OWNER;
                else state_next = ST_WRITE;
            end
            ST_LRU:    if (scan_reg == (FW+1)'(FRAME_COUNT)) state_next = ST_OWNER;
            ST_OWNER:  state_next = ST_VICTIM;
            ST_VICTIM: state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign m_valid = (state_reg == ST_OUT);
    assign m_phys_addr = {frame_reg, off_reg};
    assign m_tlb_hit = hit_reg;
    assign m_page_fault = fault_reg;
    assign m_evicted_valid = ev_reg;
    assign m_evicted_page = evp_reg;

    always_comb begin
        tv_next = tv_reg;
        if (state_reg == ST_VICTIM && pm_rdata_reg[FW] && pm_rdata_reg[FW-1:0] == frame_reg)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
                if (tag_reg[i] == fo_rdata_reg) tv_next[i] = 1'b0;
        end
        if (state_reg == ST_WRITE && !hit_reg) tv_next[tfill_reg] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            page_reg <= s_virtual_address[OFFSET_WIDTH +: PW];
            off_reg  <= s_virtual_address[OFFSET_WIDTH-1:0];
        end
        if (state_reg == ST_LOOK) begin
            hit_reg <= thit;
            fault_reg <= !thit && !pm_rdata_reg[FW];
            ev_reg <= 1'b0;
            evp_reg <= '0;
            scan_reg <= '0;
            if (thit) frame_reg <= tframe;
            else if (pm_rdata_reg[FW]) frame_reg <= pm_rdata_reg[FW-1:0];
            else frame_reg <= ffill_reg;
        end
        if (state_reg == ST_LRU) begin
            scan_reg <= scan_reg + 1'b1;
            if (scan_reg == (FW+1)'(1) || (scan_reg > (FW+1)'(1) && st_rdata_reg < best_st_reg))
            begin
                best_reg <= FW'(scan_reg - 1'b1);
                best_st_reg <= st_rdata_reg;
            end
            if (scan_reg == (FW+1)'(FRAME_COUNT)) frame_reg <= lru_pick;
        end
        if (state_reg == ST_VICTIM &&
            pm_rdata_reg[FW] && pm_rdata_reg[FW-1:0] == frame_reg) begin
            ev_reg <= 1'b1;
            evp_reg <= fo_rdata_reg;
        end
        if (state_reg == ST_WRITE && !hit_reg) begin
            tag_reg[tfill_reg] <= page_reg;
            tgt_reg[tfill_reg] <= frame_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg <= '0;
            tv_reg <= '0;
            tfill_reg <= '0;
            ffill_reg <= '0;
            full_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            tv_reg <= tv_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE && s_valid && !clearing && count_reg != '1)
                count_reg <= count_reg + 1'b1;
            if (state_reg == ST_WRITE && !hit_reg)
                tfill_reg <= (tfill_reg == TW'(TLB_ENTRIES - 1)) ? '0 : tfill_reg + 1'b1;
            if (state_reg == ST_WRITE && fault_reg) begin
                if (ffill_reg == FW'(FRAME_COUNT - 1)) begin
                    ffill_reg <= '0;
                    full_reg <= 1'b1;
                end else begin
                    ffill_reg <= ffill_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_tlb_page_table_translator.sv =====
// self-checking testbench for the tlb page table translator, fifo and lru phases
`default_nettype none
module tb_tlb_page_table_translator
    import tlbpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLB_N   = 16;
    localparam int PAGES   = 1024;
    localparam int FRAMES  = 256;
    localparam int OFS_W   = 10;
    localparam int DRAIN   = 320;
    localparam int WD_MAX  = 6000;

    typedef struct packed {
        logic [17:0] phys;
        logic        hit;
        logic        fault;
        logic        ev_valid;
        logic [9:0]  ev_page;
    } xlate_t;

    class translation_scoreboard;
        bit          mode;
        bit          map_valid [PAGES];
        bit [7:0]    map_frame [PAGES];
        bit [9:0]    frame_owner [FRAMES];
        int unsigned frame_stamp [FRAMES];
        bit [9:0]    tlb_tag [TLB_N];
        bit [7:0]    tlb_target [TLB_N];
        bit          tlb_valid [TLB_N];
        int unsigned tlb_ptr, frame_ptr, access_count;
        bit          frames_full;
        xlate_t      expected_q [$];
        int          errors, faults, evictions, hits, checked;

        function new();
            mode = 1'(MODE_FIFO);
            foreach (map_valid[i]) map_valid[i] = 0;
            foreach (tlb_valid[i]) tlb_valid[i] = 0;
            tlb_ptr = 0; frame_ptr = 0; access_count = 0; frames_full = 0;
            errors = 0; faults = 0; evictions = 0; hits = 0; checked = 0;
        endfunction

        function void note_input(logic [19:0] va);
            xlate_t      r;
            bit [9:0]    page, owner;
            bit [7:0]    frame;
            int unsigned best;
            page = va[19:10];
            r = '0;
            frame = 0;
            if (access_count != 32'hFFFF_FFFF) access_count++;
            for (int i = 0; i < TLB_N; i++) begin
                if (!r.hit && tlb_valid[i] && tlb_tag[i] == page) begin
                    r.hit = 1;
                    frame = tlb_target[i];
                end
            end
            if (!r.hit) begin
                if (map_valid[page]) begin
                    frame = map_frame[page];
                end else begin
                    r.fault = 1;
                    if (frames_full && mode == MODE_LRU) begin
                        best = 0;
                        for (int f = 1; f < FRAMES; f++)
                            if (frame_stamp[f] < frame_stamp[best]) best = f;
                        frame = best[7:0];
                    end else begin
                        frame = frame_ptr[7:0];
                    end
                    if (frames_full) begin
                        owner = frame_owner[frame];
                        if (map_valid[owner] && map_frame[owner] == frame) begin
                            map_valid[owner] = 0;
                            for (int i = 0; i < TLB_N; i++)
                                if (tlb_valid[i] && tlb_tag[i] == owner) tlb_valid[i] = 0;
                            r.ev_valid = 1;
                            r.ev_page = owner;
                        end
                    end
                    frame_ptr = (frame_ptr + 1) % FRAMES;
                    if (frame_ptr == 0) frames_full = 1;
                    map_valid[page] = 1;
                    map_frame[page] = frame;
                    frame_owner[frame] = page;
                end
                tlb_tag[tlb_ptr] = page;
                tlb_target[tlb_ptr] = frame;
                tlb_valid[tlb_ptr] = 1;
                tlb_ptr = (tlb_ptr + 1) % TLB_N;
            end
            frame_stamp[frame] = access_count;
            r.phys = {frame, va[OFS_W-1:0]};
            hits += r.hit;
            faults += r.fault;
            evictions += r.ev_valid;
            expected_q.push_back(r);
        endfunction

        function void check_result(xlate_t got);
            xlate_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.phys !== e.phys) begin
                $display("%0t: phys_addr exp %h got %h", $time, e.phys, got.phys);
                errors++;
            end
            if (got.hit !== e.hit) begin
                $display("%0t: tlb_hit exp %b got %b", $time, e.hit, got.hit);
                errors++;
            end
            if (got.fault !== e.fault) begin
                $display("%0t: page_fault exp %b got %b", $time, e.fault, got.fault);
                errors++;
            end
            if (got.ev_valid !== e.ev_valid) begin
                $display("%0t: evicted_valid exp %b got %b", $time, e.ev_valid, got.ev_valid);
                errors++;
            end
            if (got.ev_page !== e.ev_page) begin
                $display("%0t: evicted_page exp %h got %h", $time, e.ev_page, got.ev_page);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [19:0] s_virtual_address = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [17:0] m_phys_addr;
    logic        m_tlb_hit;
    logic        m_page_fault;
    logic        m_evicted_valid;
    logic [9:0]  m_evicted_page;

    translation_scoreboard sb = new();
    int          sent = 0;
    int          idle_cycles = 0;
    bit [9:0]    recent [$];
    bit [9:0]    walk_page = 0;

    tlb_page_table_translator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_virtual_address  (s_virtual_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_phys_addr        (m_phys_addr),
        .m_tlb_hit          (m_tlb_hit),
        .m_page_fault       (m_page_fault),
        .m_evicted_valid    (m_evicted_valid),
        .m_evicted_page     (m_evicted_page)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic bit quiet_stretch();
        return sent >= 300 && sent < 380;
    endfunction

    task automatic write_mode(bit v);
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.mode = v;
    endtask

    task automatic send_address(logic [19:0] va);
        s_valid <= 1;
        s_virtual_address <= va;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(va);
        sent++;
        recent.push_back(va[19:10]);
        if (recent.size() > 24) void'(recent.pop_front());
        if (!quiet_stretch() && $urandom_range(99) < 25) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic random_burst(int n);
        bit [9:0] page;
        int       pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                walk_page = walk_page + 10'($urandom_range(1, 7));
                page = walk_page;
            end else if (pick < 85 && recent.size() > 0) begin
                page = recent[$urandom_range(recent.size() - 1)];
            end else begin
                page = 10'($urandom_range(PAGES - 1));
            end
            send_address({page, 10'($urandom_range(1023))});
        end
    endtask

    // receiver with a long hold-off once 120 addresses have been sent
    initial begin
        bit held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result({m_phys_addr, m_tlb_hit, m_page_fault,
                                 m_evicted_valid, m_evicted_page});
            if (!held && sent >= 120) begin
                held = 1;
                m_ready <= 0;
                repeat (200) @(posedge aclk);
            end
            if (!aresetn) m_ready <= 0;
            else m_ready <= quiet_stretch() || ($urandom_range(99) >= 25);
        end
    end

    // watchdog on cycles with no beat moving
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_MAX) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         sb.expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_mode(1'(MODE_FIFO));

        // directed: offset and page extremes, hits, tlb overflow, page map hit
        send_address(20'h00000);
        send_address(20'hFFFFF);
        send_address(20'h003FF);
        send_address(20'hFFC00);
        send_address(20'hAAAAA);
        send_address(20'h55555);
        for (int p = 1; p <= 17; p++) send_address({10'(p * 3), 10'(p)});
        send_address(20'h00155);
        send_address(20'hFFFFF);

        random_burst(150);
        wait_idle();
        write_mode(1'(MODE_LRU));
        random_burst(200);
        wait_idle();
        write_mode(1'(MODE_FIFO));
        random_burst(100);
        wait_idle();
        write_mode(1'(MODE_LRU));
        random_burst(75);

        wait_idle();
        $display("%0d addresses translated in fifo and lru modes: %0d tlb hits, %0d faults",
                 sb.checked, sb.hits, sb.faults);
        $display("%0d evictions, %0d mismatches", sb.evictions, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/tlbpt_pkg.sv
sv/tlb_page_table_translator.sv
dv/tb_tlb_page_table_translator.sv
